// File: hw/rtl/lindblad_dissipator_macros.svh
// Assertion macros for the Lindblad dissipator block.
`ifndef LINDBLAD_DISSIPATOR_MACROS_SVH
`define LINDBLAD_DISSIPATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ld_pkg.sv
// Package: types, constants and helper functions of the Lindblad dissipator.
package ld_pkg;

   localparam int DIM          = 4;
   localparam int NUM_OPS      = 4;
   localparam int IDX_W        = 2;
   localparam int OP_W         = 2;
   localparam int DATA_W       = 32;
   localparam int ACC_W        = 64;
   localparam int PROD_SHIFT   = 9;
   localparam int PROD_W       = 2 * DATA_W - PROD_SHIFT;
   localparam int WORK_SHIFT   = 15;
   localparam int OUT_SHIFT    = 16;
   localparam int NUM_PHASES   = 6;
   localparam int DRAIN_CYCLES = 4;
   localparam int OPS_W        = 3;

   localparam logic [1:0] KIND_LOAD_DEN = 2'd0;
   localparam logic [1:0] KIND_LOAD_OP  = 2'd1;
   localparam logic [1:0] KIND_START    = 2'd2;

   localparam logic [1:0] SEL_DEN  = 2'd0;
   localparam logic [1:0] SEL_OP   = 2'd1;
   localparam logic [1:0] SEL_OPH  = 2'd2;
   localparam logic [1:0] SEL_WORK = 2'd3;

   typedef struct packed {
      logic [1:0]               kind;
      logic [OP_W-1:0]          op_index;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [DATA_W-1:0] in_re;
      logic signed [DATA_W-1:0] in_im;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_row;
      logic [IDX_W-1:0]         out_col;
      logic signed [DATA_W-1:0] out_re;
      logic signed [DATA_W-1:0] out_im;
      logic                     saturated;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] sel_a;
      logic [1:0] sel_b;
      logic       to_acc;
      logic       dbl;
   } phase_type;

   typedef struct packed {
      logic             load;
      logic             clear;
      logic             step;
      logic             step_first;
      logic             step_last;
      logic [2:0]       phase;
      logic [OP_W-1:0]  j;
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] c;
      logic [IDX_W-1:0] i;
      logic             acc_init;
      logic             emit;
      logic             emit_zero;
   } cmd_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic [1:0]       sel_a;
      logic [1:0]       sel_b;
      logic             to_acc;
      logic             dbl;
      logic             acc_init;
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] c;
   } tag_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     clip;
   } narrow_type;

   // Operand sources and destination of each of the six matrix products.
   function automatic phase_type phase_info(input logic [2:0] p);
      phase_type f;
      case (p)
         3'd0:    f = '{sel_a: SEL_OP,   sel_b: SEL_DEN, to_acc: 1'b0, dbl: 1'b0};
         3'd1:    f = '{sel_a: SEL_WORK, sel_b: SEL_OPH, to_acc: 1'b1, dbl: 1'b1};
         3'd2:    f = '{sel_a: SEL_DEN,  sel_b: SEL_OPH, to_acc: 1'b0, dbl: 1'b0};
         3'd3:    f = '{sel_a: SEL_WORK, sel_b: SEL_OP,  to_acc: 1'b1, dbl: 1'b0};
         3'd4:    f = '{sel_a: SEL_OPH,  sel_b: SEL_OP,  to_acc: 1'b0, dbl: 1'b0};
         3'd5:    f = '{sel_a: SEL_WORK, sel_b: SEL_DEN, to_acc: 1'b1, dbl: 1'b0};
         default: f = '{sel_a: SEL_WORK, sel_b: SEL_DEN, to_acc: 1'b1, dbl: 1'b0};
      endcase
      return f;
   endfunction

   // Round half up by sh bits, then saturate to DATA_W bits.
   function automatic narrow_type narrow(input logic signed [ACC_W-1:0] v, input int sh);
      logic signed [ACC_W-1:0] t;
      narrow_type n;
      t = (v + (ACC_W'(1) <<< (sh - 1))) >>> sh;
      if (t > ACC_W'(64'sh0000_0000_7FFF_FFFF)) begin
         n.val  = {1'b0, {(DATA_W-1){1'b1}}};
         n.clip = 1'b1;
      end else if (t < $signed(64'hFFFF_FFFF_8000_0000)) begin
         n.val  = {1'b1, {(DATA_W-1){1'b0}}};
         n.clip = 1'b1;
      end else begin
         n.val  = t[DATA_W-1:0];
         n.clip = 1'b0;
      end
      return n;
   endfunction

endpackage

// File: hw/rtl/ld_ctrl.sv
// Controller: sequences loads, the six products per operator, pipeline drains and output.
module ld_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ld_pkg::req_type  req_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_wdata,
   output logic             busy,
   output ld_pkg::cmd_type  cmd
);
   import ld_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RUN   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [OPS_W-1:0] active_ops_ff, active_ops_in;
   logic [OPS_W-1:0] nops_ff, nops_in;
   logic [OP_W-1:0]  j_ff, j_in;
   logic [2:0]       phase_ff, phase_in;
   logic [5:0]       step_ff, step_in;
   logic [2:0]       drain_ff, drain_in;
   logic             zero_ff, zero_in;
   logic             accept;
   logic [OPS_W-1:0] nops_sel;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign nops_sel = (active_ops_ff > OPS_W'(NUM_OPS)) ? OPS_W'(NUM_OPS) : active_ops_ff;

   always_comb begin
      state_in      = state_ff;
      active_ops_in = csr_we ? csr_wdata : active_ops_ff;
      nops_in       = nops_ff;
      j_in          = j_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      drain_in      = drain_ff;
      zero_in       = zero_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.kind == KIND_START) begin
               nops_in  = nops_sel;
               j_in     = '0;
               phase_in = '0;
               step_in  = '0;
               zero_in  = (nops_sel == '0);
               state_in = (nops_sel == '0) ? S_EMIT : S_RUN;
            end
         end
         S_RUN: begin
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               drain_in = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            drain_in = drain_ff + 3'd1;
            if (drain_ff == 3'(DRAIN_CYCLES - 1)) begin
               step_in = '0;
               if (phase_ff == 3'(NUM_PHASES - 1)) begin
                  phase_in = '0;
                  if (({1'b0, j_ff} + OPS_W'(1)) == nops_ff) begin
                     state_in = S_EMIT;
                  end else begin
                     j_in     = j_ff + OP_W'(1);
                     state_in = S_RUN;
                  end
               end else begin
                  phase_in = phase_ff + 3'd1;
                  state_in = S_RUN;
               end
            end
         end
         S_EMIT: begin
            step_in = step_ff + 6'd1;
            if (step_ff[3:0] == 4'hF) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.load       = accept && (req_data.kind == KIND_LOAD_DEN ||
                                  req_data.kind == KIND_LOAD_OP);
      cmd.clear      = accept && (req_data.kind == KIND_START);
      cmd.step       = (state_ff == S_RUN);
      cmd.step_first = (step_ff[1:0] == 2'd0);
      cmd.step_last  = (step_ff[1:0] == 2'd3);
      cmd.phase      = phase_ff;
      cmd.j          = j_ff;
      cmd.r          = (state_ff == S_EMIT) ? step_ff[3:2] : step_ff[5:4];
      cmd.c          = (state_ff == S_EMIT) ? step_ff[1:0] : step_ff[3:2];
      cmd.i          = step_ff[1:0];
      cmd.acc_init   = (j_ff == '0) && (phase_ff == 3'd1);
      cmd.emit       = (state_ff == S_EMIT);
      cmd.emit_zero  = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ops_ff <= OPS_W'(NUM_OPS);
         nops_ff       <= '0;
         j_ff          <= '0;
         phase_ff      <= '0;
         step_ff       <= '0;
         drain_ff      <= '0;
         zero_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ops_ff <= active_ops_in;
         nops_ff       <= nops_in;
         j_ff          <= j_in;
         phase_ff      <= phase_in;
         step_ff       <= step_in;
         drain_ff      <= drain_in;
         zero_ff       <= zero_in;
      end
   end

endmodule

// File: hw/rtl/ld_datapath.sv
// Datapath: element stores, complex multiply-accumulate pipeline, accumulators, output.
module ld_datapath (
   input  logic             clock,
   input  logic             reset,
   input  ld_pkg::req_type  req_data,
   input  ld_pkg::cmd_type  cmd,
   output logic             rsp_valid,
   output ld_pkg::rsp_type  rsp_data
);
   import ld_pkg::*;

   localparam int CPLX_W = 2 * DATA_W;
   localparam int MSZ    = DIM * DIM;

   logic [CPLX_W-1:0] den_mem [MSZ];
   logic [CPLX_W-1:0] opr_mem [NUM_OPS * MSZ];
   logic [CPLX_W-1:0] wk_mem  [MSZ];
   logic signed [ACC_W-1:0] acc_re_ff [MSZ];
   logic signed [ACC_W-1:0] acc_im_ff [MSZ];

   phase_type ph;
   logic [2*IDX_W-1:0]      den_addr, wk_addr;
   logic [OP_W+2*IDX_W-1:0] opr0_addr, opr1_addr;
   logic [CPLX_W-1:0] den_q, opr0_q, opr1_q, wk_q;
   tag_type tag1_ff, tag2_ff, tag3_ff;

   // Stage 0: operand addresses. A(r,i) and B(i,c); the conjugate transpose swaps indices.
   always_comb begin
      ph        = phase_info(cmd.phase);
      den_addr  = (ph.sel_a == SEL_DEN) ? {cmd.r, cmd.i} : {cmd.i, cmd.c};
      opr0_addr = (ph.sel_a == SEL_OPH) ? {cmd.j, cmd.i, cmd.r} : {cmd.j, cmd.r, cmd.i};
      opr1_addr = (ph.sel_b == SEL_OPH) ? {cmd.j, cmd.c, cmd.i} : {cmd.j, cmd.i, cmd.c};
      wk_addr   = {cmd.r, cmd.i};
   end

   // Loads write the stores; density and operator reads are registered.
   always_ff @(posedge clock) begin
      if (cmd.load && req_data.kind == KIND_LOAD_DEN) begin
         den_mem[{req_data.row, req_data.col}] <= {req_data.in_re, req_data.in_im};
      end
      den_q <= den_mem[den_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_data.kind == KIND_LOAD_OP) begin
         opr_mem[{req_data.op_index, req_data.row, req_data.col}] <=
            {req_data.in_re, req_data.in_im};
      end
      opr0_q <= opr_mem[opr0_addr];
      opr1_q <= opr_mem[opr1_addr];
   end

   // Stage 1 tag.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
      end else begin
         tag1_ff.valid <= cmd.step;
      end
      tag1_ff.first    <= cmd.step_first;
      tag1_ff.last     <= cmd.step_last;
      tag1_ff.sel_a    <= ph.sel_a;
      tag1_ff.sel_b    <= ph.sel_b;
      tag1_ff.to_acc   <= ph.to_acc;
      tag1_ff.dbl      <= ph.dbl;
      tag1_ff.acc_init <= cmd.acc_init;
      tag1_ff.r        <= cmd.r;
      tag1_ff.c        <= cmd.c;
   end

   // Stage 2: four real products, floored by PROD_SHIFT.
   logic [CPLX_W-1:0] a_op, b_op;
   logic signed [DATA_W-1:0] ar, ai, br, bi;
   logic signed [CPLX_W-1:0] m_rr, m_ii, m_ri, m_ir;
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;

   always_comb begin
      case (tag1_ff.sel_a)
         SEL_DEN:  a_op = den_q;
         SEL_OP:   a_op = opr0_q;
         SEL_OPH:  a_op = opr0_q;
         default:  a_op = wk_q;
      endcase
      case (tag1_ff.sel_b)
         SEL_DEN: b_op = den_q;
         default: b_op = opr1_q;
      endcase
      ar   = a_op[CPLX_W-1:DATA_W];
      ai   = a_op[DATA_W-1:0];
      br   = b_op[CPLX_W-1:DATA_W];
      bi   = b_op[DATA_W-1:0];
      m_rr = ar * br;
      m_ii = ai * bi;
      m_ri = ar * bi;
      m_ir = ai * br;
   end

   always_ff @(posedge clock) begin
      p_rr_ff <= m_rr[CPLX_W-1:PROD_SHIFT];
      p_ii_ff <= m_ii[CPLX_W-1:PROD_SHIFT];
      p_ri_ff <= m_ri[CPLX_W-1:PROD_SHIFT];
      p_ir_ff <= m_ir[CPLX_W-1:PROD_SHIFT];
      if (reset) begin
         tag2_ff.valid <= 1'b0;
      end else begin
         tag2_ff.valid <= tag1_ff.valid;
      end
      tag2_ff.first    <= tag1_ff.first;
      tag2_ff.last     <= tag1_ff.last;
      tag2_ff.sel_a    <= tag1_ff.sel_a;
      tag2_ff.sel_b    <= tag1_ff.sel_b;
      tag2_ff.to_acc   <= tag1_ff.to_acc;
      tag2_ff.dbl      <= tag1_ff.dbl;
      tag2_ff.acc_init <= tag1_ff.acc_init;
      tag2_ff.r        <= tag1_ff.r;
      tag2_ff.c        <= tag1_ff.c;
   end

   // Stage 3: signs of the conjugated operands applied after flooring, then summed over i.
   logic neg_a, neg_b;
   logic signed [ACC_W-1:0] e_rr, e_ii, e_ri, e_ir, term_re, term_im;
   logic signed [ACC_W-1:0] sum_re_ff, sum_im_ff;

   always_comb begin
      neg_a   = (tag2_ff.sel_a == SEL_OPH);
      neg_b   = (tag2_ff.sel_b == SEL_OPH);
      e_rr    = ACC_W'(p_rr_ff);
      e_ii    = ACC_W'(p_ii_ff);
      e_ri    = ACC_W'(p_ri_ff);
      e_ir    = ACC_W'(p_ir_ff);
      term_re = e_rr + ((neg_a ^ neg_b) ? e_ii : -e_ii);
      term_im = (neg_b ? -e_ri : e_ri) + (neg_a ? -e_ir : e_ir);
   end

   always_ff @(posedge clock) begin
      if (tag2_ff.valid) begin
         sum_re_ff <= tag2_ff.first ? term_re : sum_re_ff + term_re;
         sum_im_ff <= tag2_ff.first ? term_im : sum_im_ff + term_im;
      end
      if (reset) begin
         tag3_ff.valid <= 1'b0;
      end else begin
         tag3_ff.valid <= tag2_ff.valid;
      end
      tag3_ff.first    <= tag2_ff.first;
      tag3_ff.last     <= tag2_ff.last;
      tag3_ff.sel_a    <= tag2_ff.sel_a;
      tag3_ff.sel_b    <= tag2_ff.sel_b;
      tag3_ff.to_acc   <= tag2_ff.to_acc;
      tag3_ff.dbl      <= tag2_ff.dbl;
      tag3_ff.acc_init <= tag2_ff.acc_init;
      tag3_ff.r        <= tag2_ff.r;
      tag3_ff.c        <= tag2_ff.c;
   end

   // Stage 4: finished element goes to the work store or into the accumulators.
   logic done;
   narrow_type wn_re, wn_im;
   logic signed [ACC_W-1:0] add_re, add_im;
   logic [2*IDX_W-1:0] dst;
   logic clip_ff, clip_in;

   always_comb begin
      done   = tag3_ff.valid && tag3_ff.last;
      dst    = {tag3_ff.r, tag3_ff.c};
      wn_re  = narrow(sum_re_ff, WORK_SHIFT);
      wn_im  = narrow(sum_im_ff, WORK_SHIFT);
      add_re = tag3_ff.dbl ? (sum_re_ff <<< 1) : -sum_re_ff;
      add_im = tag3_ff.dbl ? (sum_im_ff <<< 1) : -sum_im_ff;
      clip_in = clip_ff;
      if (cmd.clear) begin
         clip_in = 1'b0;
      end else if (done && !tag3_ff.to_acc) begin
         clip_in = clip_ff | wn_re.clip | wn_im.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (done && !tag3_ff.to_acc) begin
         wk_mem[dst] <= {wn_re.val, wn_im.val};
      end
      wk_q <= wk_mem[wk_addr];
   end

   always_ff @(posedge clock) begin
      if (done && tag3_ff.to_acc) begin
         acc_re_ff[dst] <= tag3_ff.acc_init ? add_re : acc_re_ff[dst] + add_re;
         acc_im_ff[dst] <= tag3_ff.acc_init ? add_im : acc_im_ff[dst] + add_im;
      end
   end

   // Output stage.
   narrow_type on_re, on_im;
   logic signed [ACC_W-1:0] o_re, o_im;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   always_comb begin
      o_re  = cmd.emit_zero ? '0 : acc_re_ff[{cmd.r, cmd.c}];
      o_im  = cmd.emit_zero ? '0 : acc_im_ff[{cmd.r, cmd.c}];
      on_re = narrow(o_re, OUT_SHIFT);
      on_im = narrow(o_im, OUT_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clip_ff      <= clip_in;
         rsp_valid_ff <= cmd.emit;
      end
      rsp_ff.out_row   <= cmd.r;
      rsp_ff.out_col   <= cmd.c;
      rsp_ff.out_re    <= on_re.val;
      rsp_ff.out_im    <= on_im.val;
      rsp_ff.saturated <= clip_ff | on_re.clip | on_im.clip;
      rsp_ff.last      <= (cmd.r == IDX_W'(DIM - 1)) && (cmd.c == IDX_W'(DIM - 1));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hw/rtl/lindblad_dissipator.sv
// Loads may follow back to back; busy stays low for them.
// A start runs 6 products per active operator, each followed by a pipeline drain,
// then 16 results are emitted, one result per cycle.
// Results follow once the last product has drained; busy drops with the last result.
// Synchronous reset idles the controller and sets active_ops to 4; stores are not cleared.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
`include "lindblad_dissipator_macros.svh"

module lindblad_dissipator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ld_pkg::req_type  req_data,
   output logic             busy,
   input  logic             csr_we,
   input  logic [2:0]       csr_wdata,
   output logic             rsp_valid,
   output ld_pkg::rsp_type  rsp_data
);
   import ld_pkg::*;

   cmd_type cmd;

   ld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .cmd       (cmd)
   );

   ld_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `LD_ASSERT_NEXT(a_start_busy, start && !busy && req_data.kind == KIND_START, busy, "start transaction did not raise busy")
   `LD_ASSERT_NEXT(a_last_ends, rsp_valid && rsp_data.last, !rsp_valid, "result after last element")
   `LD_ASSERT_SAME(a_mid_busy, rsp_valid && !rsp_data.last, busy, "result stream while idle")

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the Lindblad dissipator: loads, starts and operator counts.
module tb_top;
   import ld_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         HALF_PERIOD = 10;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    csr_we;
   logic [2:0] csr_wdata;
   logic    rsp_valid;
   rsp_type rsp_data;

   lindblad_dissipator dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data), .busy(busy),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // shadow copy of the block state
   int     den_re[DIM*DIM], den_im[DIM*DIM];
   int     opr_re[NUM_OPS*DIM*DIM], opr_im[NUM_OPS*DIM*DIM];
   int     wk_re[DIM*DIM], wk_im[DIM*DIM];
   longint acc_re[DIM*DIM], acc_im[DIM*DIM];
   int     ops_setting;

   req_type pending_q[$];
   rsp_type dissipator_q[$];
   bit      took_item;
   int      burst_left, gap_left;
   int      mismatches, results_seen, starts_seen, loads_seen;

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   initial begin
      #(HALF_PERIOD * 2 * 3000000);
      $display("Verification failed");
      $finish;
   end

   function automatic int round_sat(input longint v, input int sh, inout bit clip);
      longint t;
      t = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (t > 64'sd2147483647) begin
         clip = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (t < -64'sd2147483648) begin
         clip = 1'b1;
         return 32'h8000_0000;
      end
      return int'(t);
   endfunction

   function automatic longint mul_q(input int a, input int b);
      return (longint'(a) * longint'(b)) >>> PROD_SHIFT;
   endfunction

   function automatic void operand(input logic [1:0] sel, input int j, r, c,
                                   output int re, output int im, output longint sg);
      sg = 1;
      case (sel)
         SEL_DEN: begin re = den_re[r*DIM+c]; im = den_im[r*DIM+c]; end
         SEL_OP: begin re = opr_re[j*DIM*DIM+r*DIM+c]; im = opr_im[j*DIM*DIM+r*DIM+c]; end
         SEL_OPH: begin
            re = opr_re[j*DIM*DIM+c*DIM+r]; im = opr_im[j*DIM*DIM+c*DIM+r]; sg = -1;
         end
         default: begin re = wk_re[r*DIM+c]; im = wk_im[r*DIM+c]; end
      endcase
   endfunction

   function automatic void dot_row_col(input logic [1:0] sa, sb, input int j, r, c,
                                       output longint sre, output longint sim);
      int ar, ai, br, bi;
      longint ga, gb;
      sre = 0;
      sim = 0;
      for (int i = 0; i < DIM; i++) begin
         operand(sa, j, r, i, ar, ai, ga);
         operand(sb, j, i, c, br, bi, gb);
         sre += mul_q(ar, br) - ga * gb * mul_q(ai, bi);
         sim += gb * mul_q(ar, bi) + ga * mul_q(ai, br);
      end
   endfunction

   function automatic void product_step(input logic [2:0] ph, input int j, inout bit wclip);
      phase_type f;
      longint sre, sim;
      int nre[DIM*DIM], nim[DIM*DIM];
      f = phase_info(ph);
      for (int k = 0; k < DIM*DIM; k++) begin
         dot_row_col(f.sel_a, f.sel_b, j, k / DIM, k % DIM, sre, sim);
         if (f.to_acc) begin
            acc_re[k] += (f.dbl ? 2 : -1) * sre;
            acc_im[k] += (f.dbl ? 2 : -1) * sim;
         end else begin
            nre[k] = round_sat(sre, WORK_SHIFT, wclip);
            nim[k] = round_sat(sim, WORK_SHIFT, wclip);
         end
      end
      if (!f.to_acc) begin
         wk_re = nre;
         wk_im = nim;
      end
   endfunction

   // Apply one accepted transaction to the shadow state; queue its results.
   function automatic void predict_dissipator(input req_type q);
      int n;
      bit wclip, clip;
      rsp_type e;
      case (q.kind)
         KIND_LOAD_DEN: begin
            den_re[q.row*DIM+q.col] = q.in_re;
            den_im[q.row*DIM+q.col] = q.in_im;
            loads_seen++;
         end
         KIND_LOAD_OP: begin
            opr_re[q.op_index*DIM*DIM+q.row*DIM+q.col] = q.in_re;
            opr_im[q.op_index*DIM*DIM+q.row*DIM+q.col] = q.in_im;
            loads_seen++;
         end
         KIND_START: begin
            starts_seen++;
            wclip = 1'b0;
            for (int k = 0; k < DIM*DIM; k++) begin
               acc_re[k] = 0;
               acc_im[k] = 0;
            end
            n = ops_setting > NUM_OPS ? NUM_OPS : ops_setting;
            for (int j = 0; j < n; j++)
               for (int p = 0; p < NUM_PHASES; p++)
                  product_step(3'(p), j, wclip);
            for (int k = 0; k < DIM*DIM; k++) begin
               clip = wclip;
               e.out_row = IDX_W'(k / DIM);
               e.out_col = IDX_W'(k % DIM);
               e.out_re = round_sat(acc_re[k], OUT_SHIFT, clip);
               e.out_im = round_sat(acc_im[k], OUT_SHIFT, clip);
               e.saturated = clip;
               e.last = (k == DIM*DIM - 1);
               dissipator_q.push_back(e);
            end
         end
         default: ;
      endcase
   endfunction

   // acceptance and result check, both on the rising edge
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && start && !busy) begin
         predict_dissipator(req_data);
         took_item = 1'b1;
      end
      if (!reset && rsp_valid) begin
         results_seen++;
         if (dissipator_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result at (%0d,%0d)", rsp_data.out_row, rsp_data.out_col);
         end else begin
            e = dissipator_q.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp row %0d col %0d re %h im %h sat %b last %b",
                     e.out_row, e.out_col, e.out_re, e.out_im, e.saturated, e.last);
                  $display("         got row %0d col %0d re %h im %h sat %b last %b",
                     rsp_data.out_row, rsp_data.out_col, rsp_data.out_re, rsp_data.out_im,
                     rsp_data.saturated, rsp_data.last);
               end
            end
         end
      end
   end

   // driver: bursts and gaps, inputs change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !took_item) begin
         // held until accepted
      end else if (pending_q.size() > 0 && gap_left == 0) begin
         req_data <= pending_q.pop_front();
         start <= 1'b1;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         start <= 1'b0;
         if (gap_left > 0)
            gap_left--;
      end
      took_item = 1'b0;
   end

   function automatic int rand_value(input bit wide);
      if (wide)
         return int'($urandom);
      return int'($urandom_range(0, 33554432)) - 16777216;
   endfunction

   function automatic req_type make_item(input logic [1:0] kind, input int op, r, c,
                                         input int re, im);
      req_type q;
      q.kind = kind;
      q.op_index = OP_W'(op);
      q.row = IDX_W'(r);
      q.col = IDX_W'(c);
      q.in_re = re;
      q.in_im = im;
      return q;
   endfunction

   function automatic void add_random_items(input int count);
      int pick;
      bit wide;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         wide = ($urandom_range(0, 9) == 0);
         if (pick < 45)
            pending_q.push_back(make_item(KIND_LOAD_DEN, $urandom_range(0, 3),
               $urandom_range(0, 3), $urandom_range(0, 3), rand_value(wide), rand_value(wide)));
         else if (pick < 85)
            pending_q.push_back(make_item(KIND_LOAD_OP, $urandom_range(0, 3),
               $urandom_range(0, 3), $urandom_range(0, 3), rand_value(wide), rand_value(wide)));
         else if (pick < 88)
            pending_q.push_back(make_item(KIND_UNUSED, $urandom_range(0, 3),
               $urandom_range(0, 3), $urandom_range(0, 3), int'($urandom), int'($urandom)));
         else
            pending_q.push_back(make_item(KIND_START, $urandom_range(0, 3),
               $urandom_range(0, 3), $urandom_range(0, 3), int'($urandom), int'($urandom)));
      end
   endfunction

   task automatic drain_and_settle();
      wait (pending_q.size() == 0 && !start);
      wait (dissipator_q.size() == 0);
      repeat (DRAIN_CYCLES + 4) @(posedge clock);
      wait (!busy);
   endtask

   task automatic write_ops(input int v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= 3'(v);
      ops_setting = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int ops_plan[8];
      ops_plan = '{1, 4, 0, 7, 2, 3, 5, 6};
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      ops_setting = 4;
      took_item = 1'b0;
      burst_left = 0;
      gap_left = 0;
      mismatches = 0;
      results_seen = 0;
      starts_seen = 0;
      loads_seen = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // every store entry gets written before the first start reads it
      for (int k = 0; k < DIM*DIM; k++)
         pending_q.push_back(make_item(KIND_LOAD_DEN, 0, k / DIM, k % DIM,
            rand_value(0), rand_value(0)));
      for (int k = 0; k < NUM_OPS*DIM*DIM; k++)
         pending_q.push_back(make_item(KIND_LOAD_OP, k / (DIM*DIM), (k / DIM) % DIM,
            k % DIM, rand_value(0), rand_value(0)));
      // reset default of four operators
      pending_q.push_back(make_item(KIND_START, 0, 0, 0, 0, 0));
      // extremes: most positive and most negative values, and zero
      pending_q.push_back(make_item(KIND_LOAD_DEN, 0, 3, 3, 32'h7FFF_FFFF, 32'h8000_0000));
      pending_q.push_back(make_item(KIND_LOAD_OP, 3, 0, 3, 32'h8000_0000, 32'h7FFF_FFFF));
      pending_q.push_back(make_item(KIND_LOAD_OP, 0, 2, 1, 0, 0));
      pending_q.push_back(make_item(KIND_UNUSED, 3, 3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_q.push_back(make_item(KIND_START, 3, 3, 3, -1, -1));
      pending_q.push_back(make_item(KIND_LOAD_DEN, 0, 3, 3, 32'h0100_0000, 0));
      pending_q.push_back(make_item(KIND_LOAD_OP, 3, 0, 3, 0, 32'hFF00_0000));
      pending_q.push_back(make_item(KIND_START, 0, 0, 0, 0, 0));
      drain_and_settle();

      foreach (ops_plan[p]) begin
         write_ops(ops_plan[p]);
         add_random_items(40);
         pending_q.push_back(make_item(KIND_START, 0, 0, 0, 0, 0));
         drain_and_settle();
      end

      repeat (20) @(posedge clock);
      $display("Ran %0d loads and %0d starts over operator counts 0 to 7; checked %0d results.",
         loads_seen, starts_seen, results_seen);
      $display("%0d mismatches, %0d results still expected.", mismatches, dissipator_q.size());
      if (mismatches == 0 && dissipator_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ld_pkg.sv
hw/rtl/ld_ctrl.sv
hw/rtl/ld_datapath.sv
hw/rtl/lindblad_dissipator.sv
tb/tb_top.sv
